/* rtl/kda_pkg.sv */
// Shared types, constants and key tables of the keypad debounce block.
package kda_pkg;

    localparam int unsigned KDA_HISTORY_DEPTH = 10;
    localparam int unsigned KDA_RING_DEPTH    = 16;

    localparam int unsigned CODE_W  = 4;
    localparam int unsigned CHAR_W  = 7;
    localparam int unsigned ROW_W   = 4;
    localparam int unsigned COL_W   = 3;
    localparam int unsigned CFG_W   = 8;
    localparam int unsigned CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_DELAY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD = 1'b1;

    localparam logic [CFG_W-1:0] INITIAL_DELAY_RST = 8'd8;
    localparam logic [CFG_W-1:0] REPEAT_PERIOD_RST = 8'd4;

    // Item function codes.
    localparam logic FUNC_SCAN = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef logic [CODE_W-1:0] t_code;
    typedef logic [CHAR_W-1:0] t_char;

    // Character write request from the debouncer to the ring.
    typedef struct packed {
        logic  valid;
        t_char ch;
    } t_push;

    // Status of the ring for the item being accepted.
    typedef struct packed {
        logic pop;
        logic ready_next;
    } t_ring_stat;

    // Key code 1..12 to ASCII, zero for any other code.
    function automatic t_char key_char(input t_code code);
        t_char ch;
        case (code)
            4'd1:    ch = 7'h31;   // '1'
            4'd2:    ch = 7'h34;   // '4'
            4'd3:    ch = 7'h37;   // '7'
            4'd4:    ch = 7'h2A;   // '*'
            4'd5:    ch = 7'h32;   // '2'
            4'd6:    ch = 7'h35;   // '5'
            4'd7:    ch = 7'h38;   // '8'
            4'd8:    ch = 7'h30;   // '0'
            4'd9:    ch = 7'h33;   // '3'
            4'd10:   ch = 7'h36;   // '6'
            4'd11:   ch = 7'h39;   // '9'
            4'd12:   ch = 7'h23;   // '#'
            default: ch = '0;
        endcase
        return ch;
    endfunction

    // Lowest active-low row and column give the key code; no key gives zero.
    function automatic t_code encode_key(input logic [ROW_W-1:0] rows,
                                         input logic [COL_W-1:0] cols);
        logic [1:0] r;
        logic [1:0] c;
        t_code      code;
        r = 2'd0;
        c = 2'd0;
        for (int i = ROW_W - 1; i >= 0; i--) begin
            if (!rows[i]) begin
                r = 2'(i);
            end
        end
        for (int i = COL_W - 1; i >= 0; i--) begin
            if (!cols[i]) begin
                c = 2'(i);
            end
        end
        if (rows == '1 || cols == '1) begin
            code = '0;
        end else begin
            code = {c, r} + 4'd1;
        end
        return code;
    endfunction

endpackage

/* rtl/kda_scan_if.sv */
// Input channel carrying scan ticks and read requests.
interface kda_scan_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [3:0] row_lines;
    logic [2:0] col_lines;

    modport source (output valid, output func, output row_lines, output col_lines,
                    input ready);
    modport sink (input valid, input func, input row_lines, input col_lines,
                  output ready);
endinterface

/* rtl/kda_char_if.sv */
// Output channel carrying one result per accepted item.
interface kda_char_if;
    logic       valid;
    logic       ready;
    logic       char_valid;
    logic [6:0] char_code;
    logic       char_ready;
    logic [3:0] debounced_code;

    modport source (output valid, output char_valid, output char_code,
                    output char_ready, output debounced_code, input ready);
    modport sink (input valid, input char_valid, input char_code,
                  input char_ready, input debounced_code, output ready);
endinterface

/* rtl/kda_debounce.sv */
// Debouncer: code history memory, per-bit counts, press/hold/repeat tracking.
module kda_debounce #(
    parameter int unsigned HISTORY_DEPTH = kda_pkg::KDA_HISTORY_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_tick,
    input  logic [kda_pkg::ROW_W-1:0]     i_row_lines,
    input  logic [kda_pkg::COL_W-1:0]     i_col_lines,
    input  logic [kda_pkg::CFG_W-1:0]     i_initial_delay,
    input  logic [kda_pkg::CFG_W-1:0]     i_repeat_period,
    output kda_pkg::t_push                o_push,
    output kda_pkg::t_code                o_stable_next
);
    import kda_pkg::*;

    localparam int unsigned PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1);

    t_code             r_hist_mem [HISTORY_DEPTH];
    t_code             r_old;
    logic [PTR_W-1:0]  r_ptr;
    logic [PTR_W-1:0]  n_ptr;
    logic              r_full;
    logic              n_full;
    logic [CNT_W-1:0]  r_cnt [CODE_W];
    logic [CNT_W-1:0]  n_cnt [CODE_W];
    t_code             r_stable;
    logic [CFG_W-1:0]  r_hold;
    logic [CFG_W-1:0]  n_hold;
    logic [CFG_W-1:0]  r_rep;
    logic [CFG_W-1:0]  n_rep;
    logic [CFG_W-1:0]  rep_inc;
    t_code             code;
    t_code             old_code;
    t_code             now;

    assign code     = encode_key(i_row_lines, i_col_lines);
    // Until the history has wrapped once, the overwritten entry is still zero.
    assign old_code = r_full ? r_old : '0;

    always_comb begin
        for (int b = 0; b < CODE_W; b++) begin
            n_cnt[b] = r_cnt[b] - CNT_W'(old_code[b]) + CNT_W'(code[b]);
            now[b]   = (n_cnt[b] == CNT_W'(HISTORY_DEPTH));
        end
    end

    always_comb begin
        if (r_ptr == PTR_W'(HISTORY_DEPTH - 1)) begin
            n_ptr  = '0;
            n_full = 1'b1;
        end else begin
            n_ptr  = r_ptr + PTR_W'(1);
            n_full = r_full;
        end
        if (!i_tick) begin
            n_ptr  = r_ptr;
            n_full = r_full;
        end
    end

    always_comb begin
        n_hold       = r_hold;
        n_rep        = r_rep;
        rep_inc      = r_rep + CFG_W'(1);
        o_push.valid = 1'b0;
        o_push.ch    = key_char(now);
        if (i_tick) begin
            if (now == '0 && r_stable == '0) begin
                n_hold = r_hold;
            end else if ((~now & r_stable) != '0) begin
                n_hold = '0;
            end else if ((now & ~r_stable) != '0) begin
                o_push.valid = 1'b1;
                n_hold       = '0;
            end else if (r_hold < i_initial_delay) begin
                n_hold = r_hold + CFG_W'(1);
                n_rep  = '0;
            end else if (rep_inc >= i_repeat_period) begin
                n_rep        = '0;
                o_push.valid = 1'b1;
            end else begin
                n_rep = rep_inc;
            end
        end
    end

    assign o_stable_next = i_tick ? now : r_stable;

    // The next pointer is read ahead, so the entry about to be replaced is ready.
    always_ff @(posedge i_clk) begin
        if (i_tick) begin
            r_hist_mem[r_ptr] <= code;
        end
        r_old <= r_hist_mem[n_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr    <= '0;
            r_full   <= 1'b0;
            r_stable <= '0;
            r_hold   <= '0;
            r_rep    <= '0;
            for (int b = 0; b < CODE_W; b++) begin
                r_cnt[b] <= '0;
            end
        end else if (i_tick) begin
            r_ptr    <= n_ptr;
            r_full   <= n_full;
            r_stable <= now;
            r_hold   <= n_hold;
            r_rep    <= n_rep;
            for (int b = 0; b < CODE_W; b++) begin
                r_cnt[b] <= n_cnt[b];
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt[0] <= CNT_W'(HISTORY_DEPTH) && r_cnt[3] <= CNT_W'(HISTORY_DEPTH))
        else $error("history bit count exceeds history depth");
    a_push_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.valid |-> (now != '0 && o_push.ch != '0))
        else $error("character pushed without a key");
    a_stable_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stable <= 4'd12)
        else $error("debounced code out of key range");
    a_full_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |=> r_full)
        else $error("history fill flag dropped without reset");
`endif

endmodule

/* rtl/kda_char_ring.sv */
// Character ring: synchronous memory with write and read pointers.
module kda_char_ring #(
    parameter int unsigned RING_DEPTH = kda_pkg::KDA_RING_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kda_pkg::t_push      i_push,
    input  logic                i_pop_req,
    output kda_pkg::t_ring_stat o_stat,
    output kda_pkg::t_char      o_rd_data
);
    import kda_pkg::*;

    localparam int unsigned PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    t_char            r_ring_mem [RING_DEPTH];
    t_char            r_rd_data;
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [PTR_W-1:0] wp_inc;
    logic [PTR_W-1:0] rp_inc;
    logic [PTR_W-1:0] n_wp;
    logic [PTR_W-1:0] n_rp;
    logic             pop;

    assign wp_inc = (r_wp == PTR_W'(RING_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
    assign rp_inc = (r_rp == PTR_W'(RING_DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
    assign pop    = i_pop_req && (r_rp != r_wp);
    assign n_wp   = i_push.valid ? wp_inc : r_wp;
    assign n_rp   = pop ? rp_inc : r_rp;

    assign o_stat.pop        = pop;
    assign o_stat.ready_next = (n_rp != n_wp);
    assign o_rd_data         = r_rd_data;

    // Read data is loaded only on a pop, so it holds while the result waits.
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_ring_mem[r_wp] <= i_push.ch;
        end
        if (pop) begin
            r_rd_data <= r_ring_mem[r_rp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push.valid && i_pop_req))
        else $error("push and pop requested for the same item");
    a_empty_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop_req && r_rp == r_wp) |=> $stable(r_rp))
        else $error("read pointer moved on an empty ring");
    a_pop_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && $past(i_rst_n)) |=> $changed(r_rp) || RING_DEPTH == 1)
        else $error("pop did not advance the read pointer");
`endif

endmodule

/* rtl/keypad_debounce_autorepeat_buffer.sv */
// Top level of the keypad debouncer with auto-repeat and character buffer.
//
// Usage: each transfer on i_scan is either a scan tick (func = 0) carrying the
// sampled active-low row and column lines of a 4x3 keypad, or a read request
// (func = 1) that pops one character from the buffer. Every accepted item
// yields exactly one transfer on o_result: the popped character and its flag
// (zero on a scan tick or an empty buffer), whether characters remain, and
// the debounced key code after the item.
// The result register loads at the accepting edge and is offered from the
// next cycle on. One item can be taken every cycle while the receiver does
// not stall; the history entry about to be replaced is read ahead, so the
// memory read latency adds no stall; a single result register sets the rate.
// When the receiver stalls, the result is held and i_scan.ready drops only
// while a result is waiting and o_result.ready is low, so a new item enters
// in the same cycle the waiting result is taken.
// Synchronous reset clears the history, the hold and repeat counters and the
// ring pointers (empty ring) and loads the initial delay with 8 and the
// repeat period with 4. Configuration writes are taken on any edge with
// i_cfg_we high; index 0 is the initial delay, index 1 the repeat period.
module keypad_debounce_autorepeat_buffer #(
    parameter int unsigned HISTORY_DEPTH = kda_pkg::KDA_HISTORY_DEPTH,
    parameter int unsigned RING_DEPTH    = kda_pkg::KDA_RING_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [kda_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [kda_pkg::CFG_W-1:0]       i_cfg_data,
    kda_scan_if.sink                        i_scan,
    kda_char_if.source                      o_result
);
    import kda_pkg::*;

    logic [CFG_W-1:0] r_initial_delay;
    logic [CFG_W-1:0] r_repeat_period;
    logic             accept;
    logic             tick;
    logic             read_req;
    t_push            push;
    t_code            stable_next;
    t_ring_stat       ring_stat;
    t_char            rd_data;

    // Result register: valid is control, the rest is payload.
    logic             r_out_valid;
    logic             r_popped;
    logic             r_char_ready;
    t_code            r_code;

    assign i_scan.ready = !r_out_valid || o_result.ready;
    assign accept       = i_scan.valid && i_scan.ready;
    assign tick         = accept && (i_scan.func == FUNC_SCAN);
    assign read_req     = accept && (i_scan.func == FUNC_READ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial_delay <= INITIAL_DELAY_RST;
            r_repeat_period <= REPEAT_PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_INITIAL_DELAY: r_initial_delay <= i_cfg_data;
                CFG_REPEAT_PERIOD: r_repeat_period <= i_cfg_data;
            endcase
        end
    end

    kda_debounce #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_debounce (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_tick          (tick),
        .i_row_lines     (i_scan.row_lines),
        .i_col_lines     (i_scan.col_lines),
        .i_initial_delay (r_initial_delay),
        .i_repeat_period (r_repeat_period),
        .o_push          (push),
        .o_stable_next   (stable_next)
    );

    kda_char_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_char_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_pop_req (read_req),
        .o_stat    (ring_stat),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_popped     <= ring_stat.pop;
            r_char_ready <= ring_stat.ready_next;
            r_code       <= stable_next;
        end
    end

    // The ring's read data register holds the popped character.
    assign o_result.valid          = r_out_valid;
    assign o_result.char_valid     = r_popped;
    assign o_result.char_code      = r_popped ? rd_data : '0;
    assign o_result.char_ready     = r_char_ready;
    assign o_result.debounced_code = r_code;

`ifndef NO_ASSERTIONS
    a_char_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_popped) |-> (o_result.char_code != '0))
        else $error("popped character is zero");
    a_scan_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick |=> !r_popped)
        else $error("scan tick returned a character");
    a_pop_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (read_req && !ring_stat.pop) |-> !ring_stat.ready_next)
        else $error("empty read reports characters pending");
`endif

endmodule
